// File: hw/rtl/kvl_pkg.sv
// ----------------------------------------------------------------------------
// kvl_pkg: shared types and constants of the key = value text lexer
// Lexer modes, event and token codes, result item layout, character classes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kvl_pkg;

	// Lexer modes
	typedef enum logic [2:0] {
		MODE_START  = 3'd0,
		MODE_IDENT  = 3'd1,
		MODE_INT    = 3'd2,
		MODE_REAL   = 3'd3,
		MODE_STRING = 3'd4
	} mode_t;

	// Event codes
	localparam logic [1:0] EV_CHAR = 2'd0;
	localparam logic [1:0] EV_DONE = 2'd1;
	localparam logic [1:0] EV_ERR  = 2'd2;

	// Token kinds
	localparam logic [2:0] KIND_IDENT  = 3'd0;
	localparam logic [2:0] KIND_NUMBER = 3'd1;
	localparam logic [2:0] KIND_ASSIGN = 3'd2;
	localparam logic [2:0] KIND_STRING = 3'd3;
	localparam logic [2:0] KIND_EOT    = 3'd4;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	// One result item
	typedef struct packed {
		logic [1:0] event_res;
		logic [2:0] token_kind;
		logic [7:0] char_out;
		logic       last;
	} result_t;

	// Results of one step, handed from the lexer core to the result queue
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} step_res_t;

	function automatic result_t make_res(logic [1:0] ev, logic [2:0] kind, logic [7:0] ch);
		result_t r;
		r.event_res  = ev;
		r.token_kind = kind;
		r.char_out   = ch;
		r.last       = 1'b0;
		return r;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
	endfunction

	function automatic logic is_ident(logic [7:0] c);
		return is_digit(c) || is_alpha(c) || (c == CH_MINUS) || (c == CH_UNDER);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/kvl_if.sv
// ----------------------------------------------------------------------------
// kvl_if: channel interfaces of the key = value text lexer
// Text byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kvl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_text;

	modport source (output valid, output char_in, output end_of_text, input ready);
	modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface kvl_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic [2:0] token_kind;
	logic [7:0] char_out;
	logic       last;

	modport source (output valid, output event_res, output token_kind, output char_out,
		output last, input ready);
	modport sink (input valid, input event_res, input token_kind, input char_out,
		input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/kvl_lexer_core.sv
// ----------------------------------------------------------------------------
// kvl_lexer_core: input register, lexer state and step logic
// Registers one text byte, then classifies it against the lexer mode and
// produces up to two result items per byte in one pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvl_lexer_core import kvl_pkg::*; #(
	parameter int MAX_VALUE_CHARS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_in,
	input  wire logic       end_of_text,
	input  wire logic       room,
	output step_res_t       step
);

	localparam int LEN_W = $clog2(MAX_VALUE_CHARS);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_VALUE_CHARS - 1);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             eot_s1;
	mode_t            mode_q;
	mode_t            mode_d;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_d;
	logic             adv;
	logic [7:0]       c;
	logic             endmark;
	logic             len_ok;
	logic             fresh;
	logic [1:0]       n_c;
	result_t          res_c [2];

	// Advance the held byte once the queue can take two results
	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
			eot_s1  <= end_of_text;
		end
	end

	assign c       = eot_s1 ? CH_NUL : char_s1;
	assign endmark = eot_s1 || (c == CH_NUL) || (c == CH_ETX);
	assign len_ok  = len_q < LEN_MAX;

	// Step logic: mode handling, then a fresh start for the byte that ends a token
	always_comb begin
		res_c[0] = make_res(EV_CHAR, KIND_IDENT, CH_NUL);
		res_c[1] = make_res(EV_CHAR, KIND_IDENT, CH_NUL);
		n_c      = 2'd0;
		mode_d   = mode_q;
		len_d    = len_q;
		fresh    = 1'b0;

		unique case (mode_q)
			MODE_IDENT: begin
				if (!endmark && is_ident(c)) begin
					if (len_ok) begin
						res_c[n_c[0]] = make_res(EV_CHAR, KIND_IDENT, c);
						n_c           = n_c + 2'd1;
						len_d         = len_q + LEN_W'(1);
					end
				end else begin
					res_c[n_c[0]] = make_res(EV_DONE, KIND_IDENT, CH_NUL);
					n_c           = n_c + 2'd1;
					fresh         = 1'b1;
				end
			end
			MODE_INT: begin
				if (!endmark && (is_digit(c) || (c == CH_DOT))) begin
					if (len_ok) begin
						res_c[n_c[0]] = make_res(EV_CHAR, KIND_NUMBER, c);
						n_c           = n_c + 2'd1;
						len_d         = len_q + LEN_W'(1);
					end
					if (c == CH_DOT) begin
						mode_d = MODE_REAL;
					end
				end else if (endmark || is_space(c)) begin
					res_c[n_c[0]] = make_res(EV_DONE, KIND_NUMBER, CH_NUL);
					n_c           = n_c + 2'd1;
					fresh         = 1'b1;
				end else begin
					res_c[n_c[0]] = make_res(EV_ERR, KIND_NUMBER, c);
					n_c           = n_c + 2'd1;
				end
			end
			MODE_REAL: begin
				if (!endmark && is_digit(c)) begin
					if (len_ok) begin
						res_c[n_c[0]] = make_res(EV_CHAR, KIND_NUMBER, c);
						n_c           = n_c + 2'd1;
						len_d         = len_q + LEN_W'(1);
					end
				end else begin
					res_c[n_c[0]] = make_res(EV_DONE, KIND_NUMBER, CH_NUL);
					n_c           = n_c + 2'd1;
					fresh         = 1'b1;
				end
			end
			MODE_STRING: begin
				if (endmark) begin
					// Unterminated string: flag it, then close the text
					res_c[0] = make_res(EV_ERR, KIND_STRING, CH_NUL);
					res_c[1] = make_res(EV_DONE, KIND_EOT, CH_NUL);
					n_c      = 2'd2;
					mode_d   = MODE_START;
				end else if (c == CH_QUOTE) begin
					res_c[n_c[0]] = make_res(EV_DONE, KIND_STRING, CH_NUL);
					n_c           = n_c + 2'd1;
					mode_d        = MODE_START;
				end else if (len_ok) begin
					res_c[n_c[0]] = make_res(EV_CHAR, KIND_STRING, c);
					n_c           = n_c + 2'd1;
					len_d         = len_q + LEN_W'(1);
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		if (fresh) begin
			mode_d = MODE_START;
			priority if (endmark) begin
				res_c[n_c[0]] = make_res(EV_DONE, KIND_EOT, CH_NUL);
				n_c           = n_c + 2'd1;
			end else if (is_space(c)) begin
				// whitespace between tokens gives no result
			end else if (is_alpha(c) || (c == CH_UNDER)) begin
				res_c[n_c[0]] = make_res(EV_CHAR, KIND_IDENT, c);
				n_c           = n_c + 2'd1;
				len_d         = LEN_W'(1);
				mode_d        = MODE_IDENT;
			end else if (is_digit(c) || (c == CH_MINUS)) begin
				res_c[n_c[0]] = make_res(EV_CHAR, KIND_NUMBER, c);
				n_c           = n_c + 2'd1;
				len_d         = LEN_W'(1);
				mode_d        = MODE_INT;
			end else if (c == CH_EQUAL) begin
				res_c[n_c[0]] = make_res(EV_DONE, KIND_ASSIGN, CH_NUL);
				n_c           = n_c + 2'd1;
			end else if (c == CH_QUOTE) begin
				len_d  = '0;
				mode_d = MODE_STRING;
			end else begin
				res_c[n_c[0]] = make_res(EV_ERR, KIND_IDENT, c);
				n_c           = n_c + 2'd1;
			end
		end

		// Mark the final result of this byte
		if (n_c == 2'd2) begin
			res_c[1].last = 1'b1;
		end else if (n_c == 2'd1) begin
			res_c[0].last = 1'b1;
		end
	end

	// Lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			len_q  <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			len_q  <= len_d;
		end
	end

	assign step.cnt = adv ? n_c : 2'd0;
	assign step.r0  = res_c[0];
	assign step.r1  = res_c[1];

endmodule

`default_nettype wire

// File: hw/rtl/kvl_result_fifo.sv
// ----------------------------------------------------------------------------
// kvl_result_fifo: result queue
// Takes up to two result items per cycle, hands out one per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvl_result_fifo import kvl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  step_res_t step,
	output logic      room,
	output logic      out_valid,
	input  wire logic out_ready,
	output result_t   out_res
);

	result_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wptr_q;
	logic [FIFO_PTR_W-1:0] rptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign out_valid = count_q != '0;
	assign out_res   = mem_q[rptr_q];
	assign pop       = out_valid && out_ready;
	// Leave space for a full two-result step
	assign room      = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

	// Store incoming results
	always_ff @(posedge clk) begin
		if (step.cnt != 2'd0) begin
			mem_q[wptr_q] <= step.r0;
		end
		if (step.cnt == 2'd2) begin
			mem_q[wptr_q + FIFO_PTR_W'(1)] <= step.r1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + FIFO_PTR_W'(step.cnt);
			rptr_q  <= rptr_q + FIFO_PTR_W'(pop);
			count_q <= count_q + FIFO_CNT_W'(step.cnt) - FIFO_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/key_value_text_lexer_top.sv
// Path: an accepted text byte is held in the input register, its results are
//   written into the result queue, and they leave from the queue.
// Throughput: one text byte per cycle while the queue holds at most two results;
//   results leave one per cycle, while res_out is ready, from a four-entry queue.
// Reset: arst_n clears lexer mode, value length, input valid, queue pointers, count.
// ----------------------------------------------------------------------------
// key_value_text_lexer_top: key = value text lexer
// Tokenizes a byte stream into identifiers, numbers, '=' and strings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_value_text_lexer_top import kvl_pkg::*; #(
	parameter int MAX_VALUE_CHARS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	kvl_in_if.sink    text_in,
	kvl_out_if.source res_out
);

	step_res_t step;
	logic      room;
	logic      out_valid;
	result_t   out_res;

	// Lexer core
	kvl_lexer_core #(
		.MAX_VALUE_CHARS(MAX_VALUE_CHARS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (text_in.valid),
		.in_ready   (text_in.ready),
		.char_in    (text_in.char_in),
		.end_of_text(text_in.end_of_text),
		.room       (room),
		.step       (step)
	);

	// Result queue
	kvl_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(res_out.ready),
		.out_res  (out_res)
	);

	assign res_out.valid      = out_valid;
	assign res_out.event_res  = out_res.event_res;
	assign res_out.token_kind = out_res.token_kind;
	assign res_out.char_out   = out_res.char_out;
	assign res_out.last       = out_res.last;

endmodule

`default_nettype wire

// File: hw/rtl/kvl_checker.sv
// ----------------------------------------------------------------------------
// kvl_checker: port checks of the key = value text lexer
// Watches the result channel for well-formed result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvl_checker import kvl_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] event_res,
	input wire logic [2:0] token_kind,
	input wire logic [7:0] char_out,
	input wire logic       last
);

	// Hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(char_out)
			&& $stable(token_kind) && $stable(last))
		else $error("result changed while stalled");

	// An unterminated string is always followed by the end-of-text token
	a_unterm_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_ERR) && (token_kind == KIND_STRING) |-> !last)
		else $error("unterminated string marked last");

	// Token-complete events carry no character
	a_done_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_DONE) |-> char_out == CH_NUL)
		else $error("token complete with character");

	// Value characters belong to identifiers, numbers or strings
	a_char_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_CHAR) |->
			(token_kind == KIND_IDENT) || (token_kind == KIND_NUMBER)
			|| (token_kind == KIND_STRING))
		else $error("value character with bad kind");

endmodule

bind key_value_text_lexer_top kvl_checker u_kvl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.event_res (res_out.event_res),
	.token_kind(res_out.token_kind),
	.char_out  (res_out.char_out),
	.last      (res_out.last)
);

`default_nettype wire
